### sv/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

    localparam int THREAD_COUNT_DEF = 64;

    localparam int ID_W    = 6;
    localparam int CHAN_W  = 32;
    localparam int ACT_W   = 3;
    localparam int SLICE_W = 16;
    localparam int TICK_W  = 10;
    localparam int WOKEN_W = 7;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd5;
    localparam logic [TICK_W-1:0]  TICK_RESET  = 10'd1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_YIELD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WAKEUP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ADMIT  = 3'd4;

    // thread status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_SLEEP = 2'd3;

    // register indexes
    localparam int REG_SLICE = 0;
    localparam int REG_TICK  = 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_ADMIT_RD,
        S_ADMIT_CHK,
        S_POP_RD,
        S_POP_WAIT,
        S_APPLY,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

### sv/rrts_thread_mem.sv
`default_nettype none
// Per-thread store: status and wait channel, one read port, one write port.
module rrts_thread_mem #(
    parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF,
    parameter int IDX_W        = $clog2(THREAD_COUNT)
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [IDX_W-1:0]          waddr,
    input  wire logic [1:0]                wstatus,
    input  wire logic [rrts_pkg::CHAN_W-1:0] wchan,
    input  wire logic [IDX_W-1:0]          raddr,
    output logic      [1:0]                rstatus,
    output logic      [rrts_pkg::CHAN_W-1:0] rchan
);
    logic [1:0]                  status_mem [THREAD_COUNT];
    logic [rrts_pkg::CHAN_W-1:0] chan_mem   [THREAD_COUNT];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            status_mem[waddr] <= wstatus;
            chan_mem[waddr]   <= wchan;
        end
        rstatus <= status_mem[raddr];
        rchan   <= chan_mem[raddr];
    end
endmodule
`default_nettype wire

### sv/rrts_fifo_mem.sv
`default_nettype none
// Ready queue storage: one write port, one registered read port.
module rrts_fifo_mem #(
    parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF,
    parameter int IDX_W        = $clog2(THREAD_COUNT)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [IDX_W-1:0] wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output logic      [IDX_W-1:0] rdata
);
    logic [IDX_W-1:0] mem [THREAD_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/round_robin_thread_scheduler.sv
`default_nettype none
// Round-robin thread scheduler for one CPU.
// s_ channel: one action per transfer (tick, yield, sleep, wakeup, admit).
// m_ channel: exactly one result per action: switched, from_id, to_id,
// error and woken_count.
// APB port: register 0 slice_length at 0x0, register 1 tick_length at 0x4;
// write only while no action is in flight.
// Thread status and wait channels live in one single-port-read memory,
// the ready queue in a second one; both have a registered read.
// After reset the block sweeps the thread memory with s_tready low,
// then leaves thread 0 running.
// Admit reads, then checks the thread entry; tick/yield/sleep read and pop
// the ready queue, then apply the switch, when the queue is popped; unknown
// actions go straight to the result; wakeup reads and checks every entry.
// One action is worked on at a time; s_tready rises in the cycle after the
// result is loaded. A stalled m_tready holds the result in the output
// register; the next action is still taken and worked on, then waits for
// the register to free. Nothing is dropped.
module round_robin_thread_scheduler #(
    parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] action, [8:3] thread_id, [40:9] channel, [47:41] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] switched, [6:1] from_id, [12:7] to_id, [13] error,
    // [20:14] woken_count, [23:21] zero
    output logic [23:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IDX_W = $clog2(THREAD_COUNT);
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);
    localparam int ID_W  = rrts_pkg::ID_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(THREAD_COUNT);

    // registers
    rrts_pkg::state_t state_reg, state_next;
    logic [rrts_pkg::SLICE_W-1:0] slice_len_reg, slice_cnt_reg, slice_cnt_next;
    logic [rrts_pkg::TICK_W-1:0]  tick_len_reg;
    logic [IDX_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] run_reg, run_next, from_reg, from_next;
    logic [IDX_W-1:0] idx_reg, idx_next, nxt_reg, nxt_next;
    logic [rrts_pkg::ACT_W-1:0] act_reg, act_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [rrts_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic [rrts_pkg::WOKEN_W-1:0] woken_reg, woken_next;
    logic err_reg, err_next;
    logic out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // memory ports
    logic                 tm_we;
    logic [IDX_W-1:0]     tm_waddr, tm_raddr;
    logic [1:0]           tm_wstatus, tm_rstatus;
    logic [rrts_pkg::CHAN_W-1:0] tm_wchan, tm_rchan;
    logic                 fm_we;
    logic [IDX_W-1:0]     fm_waddr, fm_wdata, fm_raddr, fm_rdata;

    rrts_thread_mem #(.THREAD_COUNT(THREAD_COUNT), .IDX_W(IDX_W)) u_thread_mem (
        .aclk(aclk), .we(tm_we), .waddr(tm_waddr), .wstatus(tm_wstatus),
        .wchan(tm_wchan), .raddr(tm_raddr), .rstatus(tm_rstatus), .rchan(tm_rchan)
    );

    rrts_fifo_mem #(.THREAD_COUNT(THREAD_COUNT), .IDX_W(IDX_W)) u_fifo_mem (
        .aclk(aclk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
        .raddr(fm_raddr), .rdata(fm_rdata)
    );

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // APB
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {16'd0, slice_len_reg};
            default: prdata = {22'd0, tick_len_reg};
        endcase
    end

    assign s_tready = (state_reg == rrts_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    logic [rrts_pkg::SLICE_W:0] tick_sum;
    assign tick_sum = {1'b0, slice_cnt_reg} + (rrts_pkg::SLICE_W+1)'(tick_len_reg);

    logic tid_ok;
    assign tid_ok = (32'(tid_reg) < THREAD_COUNT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::S_CLEAR:     if (idx_reg == LAST_IDX) state_next = rrts_pkg::S_IDLE;
            rrts_pkg::S_IDLE:      if (in_xfer) state_next = rrts_pkg::S_DECIDE;
            rrts_pkg::S_DECIDE: begin
                unique case (act_reg)
                    rrts_pkg::ACT_TICK:
                        state_next = (tick_sum >= (rrts_pkg::SLICE_W+1)'(slice_len_reg)
                                      && count_reg != '0)
                                     ? rrts_pkg::S_POP_RD : rrts_pkg::S_OUT;
                    rrts_pkg::ACT_YIELD, rrts_pkg::ACT_SLEEP:
                        state_next = (count_reg != '0) ? rrts_pkg::S_POP_RD
                                                       : rrts_pkg::S_OUT;
                    rrts_pkg::ACT_WAKEUP: state_next = rrts_pkg::S_SCAN_RD;
                    rrts_pkg::ACT_ADMIT:
                        state_next = tid_ok ? rrts_pkg::S_ADMIT_RD : rrts_pkg::S_OUT;
                    default: state_next = rrts_pkg::S_OUT;
                endcase
            end
            rrts_pkg::S_ADMIT_RD:  state_next = rrts_pkg::S_ADMIT_CHK;
            rrts_pkg::S_ADMIT_CHK: state_next = rrts_pkg::S_OUT;
            rrts_pkg::S_POP_RD:    state_next = rrts_pkg::S_POP_WAIT;
            rrts_pkg::S_POP_WAIT:  state_next = rrts_pkg::S_APPLY;
            rrts_pkg::S_APPLY:     state_next = rrts_pkg::S_OUT;
            rrts_pkg::S_SCAN_RD:   state_next = rrts_pkg::S_SCAN_CHK;
            rrts_pkg::S_SCAN_CHK:
                state_next = (idx_reg == LAST_IDX) ? rrts_pkg::S_OUT
                                                   : rrts_pkg::S_SCAN_RD;
            rrts_pkg::S_OUT:       if (out_free) state_next = rrts_pkg::S_IDLE;
            default:               state_next = rrts_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        slice_cnt_next = slice_cnt_reg;
        head_next = head_reg; tail_next = tail_reg; count_next = count_reg;
        run_next = run_reg; from_next = from_reg; idx_next = idx_reg;
        nxt_next = nxt_reg; act_next = act_reg; tid_next = tid_reg;
        chan_next = chan_reg; woken_next = woken_reg; err_next = err_reg;
        out_valid_next = out_valid_reg; out_data_next = out_data_reg;
        tm_we = 1'b0; tm_waddr = idx_reg; tm_wstatus = rrts_pkg::ST_FREE;
        tm_wchan = '0; tm_raddr = idx_reg;
        fm_we = 1'b0; fm_waddr = tail_reg; fm_wdata = idx_reg; fm_raddr = head_reg;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        unique case (state_reg)
            rrts_pkg::S_CLEAR: begin
                // sweep the thread store; thread 0 runs
                tm_we = 1'b1;
                tm_wstatus = (idx_reg == '0) ? rrts_pkg::ST_RUN : rrts_pkg::ST_FREE;
                idx_next = wrap_inc(idx_reg);
            end
            rrts_pkg::S_IDLE: begin
                if (in_xfer) begin
                    act_next = s_tdata[2:0];
                    tid_next = s_tdata[8:3];
                    chan_next = s_tdata[40:9];
                    from_next = run_reg;
                    woken_next = '0;
                    err_next = 1'b0;
                    idx_next = '0;
                end
            end
            rrts_pkg::S_DECIDE: begin
                if (act_reg == rrts_pkg::ACT_TICK) begin
                    slice_cnt_next = (tick_sum >= (rrts_pkg::SLICE_W+1)'(slice_len_reg))
                                     ? '0 : tick_sum[rrts_pkg::SLICE_W-1:0];
                end
                if (act_reg == rrts_pkg::ACT_SLEEP && count_reg == '0) err_next = 1'b1;
                idx_next = (act_reg == rrts_pkg::ACT_ADMIT) ? tid_reg[IDX_W-1:0] : '0;
            end
            rrts_pkg::S_ADMIT_RD: begin
                tm_raddr = idx_reg;
            end
            rrts_pkg::S_ADMIT_CHK: begin
                if (tm_rstatus == rrts_pkg::ST_FREE && count_reg != FULL_CNT) begin
                    tm_we = 1'b1; tm_waddr = idx_reg; tm_wstatus = rrts_pkg::ST_READY;
                    tm_wchan = tm_rchan;
                    fm_we = 1'b1; fm_wdata = idx_reg;
                    tail_next = wrap_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            rrts_pkg::S_POP_RD: begin
                fm_raddr = head_reg;
            end
            rrts_pkg::S_POP_WAIT: begin
                // pop head; mark the old thread
                nxt_next = fm_rdata;
                head_next = wrap_inc(head_reg);
                tm_we = 1'b1; tm_waddr = run_reg;
                if (act_reg == rrts_pkg::ACT_SLEEP) begin
                    tm_wstatus = rrts_pkg::ST_SLEEP; tm_wchan = chan_reg;
                    count_next = count_reg - 1'b1;
                end else begin
                    // requeue old thread; count unchanged
                    tm_wstatus = rrts_pkg::ST_READY; tm_wchan = '0;
                    fm_we = 1'b1; fm_wdata = run_reg;
                    tail_next = wrap_inc(tail_reg);
                end
            end
            rrts_pkg::S_APPLY: begin
                // running thread keeps its channel, which is zero here
                tm_we = 1'b1; tm_waddr = nxt_reg; tm_wstatus = rrts_pkg::ST_RUN;
                tm_wchan = '0;
                run_next = nxt_reg;
            end
            rrts_pkg::S_SCAN_RD: begin
                tm_raddr = idx_reg;
            end
            rrts_pkg::S_SCAN_CHK: begin
                if (tm_rstatus == rrts_pkg::ST_SLEEP && tm_rchan == chan_reg) begin
                    tm_we = 1'b1; tm_waddr = idx_reg; tm_wstatus = rrts_pkg::ST_READY;
                    tm_wchan = '0;
                    woken_next = woken_reg + 1'b1;
                    if (count_reg != FULL_CNT) begin
                        fm_we = 1'b1; fm_wdata = idx_reg;
                        tail_next = wrap_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                idx_next = wrap_inc(idx_reg);
            end
            rrts_pkg::S_OUT: begin
                // load the result once the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next = {3'd0, woken_reg, err_reg,
                                     ID_W'(run_reg), ID_W'(from_reg),
                                     run_reg != from_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrts_pkg::S_CLEAR;
            slice_len_reg <= rrts_pkg::SLICE_RESET;
            tick_len_reg <= rrts_pkg::TICK_RESET;
            slice_cnt_reg <= '0;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            run_reg <= '0; idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            slice_cnt_reg <= slice_cnt_next;
            head_reg <= head_next; tail_reg <= tail_next; count_reg <= count_next;
            run_reg <= run_next; idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr) begin
                unique case (paddr[2])
                    1'(rrts_pkg::REG_SLICE): slice_len_reg <= pwdata[15:0];
                    default:                 tick_len_reg  <= pwdata[9:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        from_reg <= from_next; nxt_reg <= nxt_next; act_reg <= act_next;
        tid_reg <= tid_next; chan_reg <= chan_next; woken_reg <= woken_next;
        err_reg <= err_next; out_data_reg <= out_data_next;
    end
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int THREADS = rrts_pkg::THREAD_COUNT_DEF;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int PHASES = 5;

    typedef struct packed {
        logic                         switched;
        logic [rrts_pkg::ID_W-1:0]    from_id;
        logic [rrts_pkg::ID_W-1:0]    to_id;
        logic                         error;
        logic [rrts_pkg::WOKEN_W-1:0] woken_count;
    } sched_result_t;

    typedef struct {
        logic [rrts_pkg::ACT_W-1:0]  action;
        logic [rrts_pkg::ID_W-1:0]   thread_id;
        logic [rrts_pkg::CHAN_W-1:0] channel;
        bit                          typed;
        sched_result_t               res;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    round_robin_thread_scheduler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // scheduler mirror
    logic [rrts_pkg::SLICE_W-1:0] slice_len;
    logic [rrts_pkg::TICK_W-1:0]  tick_len;
    logic [1:0]                   thr_status [THREADS];
    logic [rrts_pkg::CHAN_W-1:0]  thr_chan [THREADS];
    logic [rrts_pkg::ID_W-1:0]    ready_ids [$];
    logic [rrts_pkg::ID_W-1:0]    cur_id;
    int unsigned                  slice_acc;

    sched_result_t pending_results [$];
    int failures = 0;
    int checked = 0;
    int switches = 0;
    int sleep_errors = 0;
    int wakeups_hit = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int cyc = 0;
    logic [rrts_pkg::CHAN_W-1:0] chan_pool [4];

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic void mirror_reset();
        slice_len = rrts_pkg::SLICE_RESET;
        tick_len  = rrts_pkg::TICK_RESET;
        for (int i = 0; i < THREADS; i++) begin
            thr_status[i] = rrts_pkg::ST_FREE;
            thr_chan[i] = '0;
        end
        thr_status[0] = rrts_pkg::ST_RUN;
        ready_ids.delete();
        cur_id = '0;
        slice_acc = 0;
    endfunction

    function automatic void rotate_running();
        logic [rrts_pkg::ID_W-1:0] nxt;
        if (ready_ids.size() == 0) return;
        nxt = ready_ids.pop_front();
        thr_status[cur_id] = rrts_pkg::ST_READY;
        ready_ids.push_back(cur_id);
        thr_status[nxt] = rrts_pkg::ST_RUN;
        cur_id = nxt;
    endfunction

    function automatic sched_result_t schedule_action(logic [rrts_pkg::ACT_W-1:0] act,
                                                      logic [rrts_pkg::ID_W-1:0] tid,
                                                      logic [rrts_pkg::CHAN_W-1:0] chan);
        sched_result_t r;
        int unsigned sum;
        logic [rrts_pkg::ID_W-1:0] nxt;
        r = '0;
        r.from_id = cur_id;
        case (act)
            rrts_pkg::ACT_TICK: begin
                sum = slice_acc + tick_len;
                if (sum >= slice_len) begin
                    slice_acc = 0;
                    rotate_running();
                end else begin
                    slice_acc = sum;
                end
            end
            rrts_pkg::ACT_YIELD: rotate_running();
            rrts_pkg::ACT_SLEEP: begin
                if (ready_ids.size() == 0) begin
                    r.error = 1'b1;
                end else begin
                    nxt = ready_ids.pop_front();
                    thr_status[cur_id] = rrts_pkg::ST_SLEEP;
                    thr_chan[cur_id] = chan;
                    thr_status[nxt] = rrts_pkg::ST_RUN;
                    cur_id = nxt;
                end
            end
            rrts_pkg::ACT_WAKEUP: begin
                for (int i = 0; i < THREADS; i++) begin
                    if (thr_status[i] == rrts_pkg::ST_SLEEP && thr_chan[i] == chan) begin
                        thr_status[i] = rrts_pkg::ST_READY;
                        thr_chan[i] = '0;
                        ready_ids.push_back(rrts_pkg::ID_W'(i));
                        r.woken_count++;
                    end
                end
            end
            rrts_pkg::ACT_ADMIT: begin
                if (thr_status[tid] == rrts_pkg::ST_FREE && ready_ids.size() < THREADS) begin
                    thr_status[tid] = rrts_pkg::ST_READY;
                    ready_ids.push_back(tid);
                end
            end
            default: ;
        endcase
        r.to_id = cur_id;
        r.switched = (cur_id != r.from_id);
        return r;
    endfunction

    // receiver: m_tready stalls at a randomly re-chosen density
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 90;
            endcase
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each result transfer against the oldest prediction
    always @(posedge aclk) begin
        sched_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[6:1], m_tdata[12:7], m_tdata[13], m_tdata[20:14]};
            if (pending_results.size() == 0) begin
                $error("result with no pending prediction: %h", m_tdata);
                failures++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got.switched != want.switched) begin
                    $error("switched: expected %0d, got %0d", want.switched, got.switched);
                    failures++;
                end
                if (got.from_id != want.from_id) begin
                    $error("from_id: expected %0d, got %0d", want.from_id, got.from_id);
                    failures++;
                end
                if (got.to_id != want.to_id) begin
                    $error("to_id: expected %0d, got %0d", want.to_id, got.to_id);
                    failures++;
                end
                if (got.error != want.error) begin
                    $error("error: expected %0d, got %0d", want.error, got.error);
                    failures++;
                end
                if (got.woken_count != want.woken_count) begin
                    $error("woken_count: expected %0d, got %0d",
                           want.woken_count, got.woken_count);
                    failures++;
                end
            end
        end
    end

    // drive one action and hold it until the transfer; sender runs in bursts
    task automatic send_action(logic [rrts_pkg::ACT_W-1:0] act,
                               logic [rrts_pkg::ID_W-1:0] tid,
                               logic [rrts_pkg::CHAN_W-1:0] chan, bit typed,
                               sched_result_t typed_res);
        sched_result_t r;
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, chan, tid, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = schedule_action(act, tid, chan);
        if (typed && r != typed_res) begin
            $error("directed row: typed %h, predictor %h", typed_res, r);
            failures++;
        end
        if (r.switched) switches++;
        if (r.error) sleep_errors++;
        if (r.woken_count != 0) wakeups_hit++;
        pending_results.push_back(typed ? typed_res : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(4 * rrts_pkg::REG_SLICE)) slice_len = data[rrts_pkg::SLICE_W-1:0];
        else if (addr == 3'(4 * rrts_pkg::REG_TICK)) tick_len = data[rrts_pkg::TICK_W-1:0];
    endtask

    task automatic random_action();
        int pick;
        logic [rrts_pkg::ACT_W-1:0] act;
        logic [rrts_pkg::ID_W-1:0] tid;
        logic [rrts_pkg::CHAN_W-1:0] chan;
        pick = $urandom_range(0, 99);
        tid = rrts_pkg::ID_W'($urandom_range(0, THREADS - 1));
        chan = chan_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 19) == 0) chan_pool[3] = $urandom;
        if (pick < 20) act = rrts_pkg::ACT_ADMIT;
        else if (pick < 45) act = rrts_pkg::ACT_TICK;
        else if (pick < 60) act = rrts_pkg::ACT_YIELD;
        else if (pick < 78) act = rrts_pkg::ACT_SLEEP;
        else if (pick < 95) act = rrts_pkg::ACT_WAKEUP;
        else act = rrts_pkg::ACT_W'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0) chan = $urandom;
        send_action(act, tid, chan, 1'b0, '0);
    endtask

    stim_row_t directed [] = '{
        '{rrts_pkg::ACT_TICK,   6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_YIELD,  6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_SLEEP,  6'd0,  32'hFFFF_FFFF, 1, '{0, 0, 0, 1, 0}},
        '{3'd7,                 6'd63, 32'hFFFF_FFFF, 1, '{0, 0, 0, 0, 0}},
        '{3'd5,                 6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_WAKEUP, 6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_ADMIT,  6'd63, 32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_ADMIT,  6'd63, 32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_ADMIT,  6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_YIELD,  6'd0,  32'h0,         1, '{1, 0, 63, 0, 0}},
        '{rrts_pkg::ACT_YIELD,  6'd0,  32'h0,         1, '{1, 63, 0, 0, 0}},
        '{rrts_pkg::ACT_SLEEP,  6'd0,  32'h0,         1, '{1, 0, 63, 0, 0}},
        '{rrts_pkg::ACT_WAKEUP, 6'd0,  32'h0,         1, '{0, 63, 63, 0, 1}},
        '{rrts_pkg::ACT_YIELD,  6'd0,  32'h0,         1, '{1, 63, 0, 0, 0}},
        '{rrts_pkg::ACT_TICK,   6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_TICK,   6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_TICK,   6'd0,  32'h0,         1, '{0, 0, 0, 0, 0}},
        '{rrts_pkg::ACT_TICK,   6'd0,  32'h0,         1, '{1, 0, 63, 0, 0}},
        '{rrts_pkg::ACT_ADMIT,  6'd1,  32'h0,         0, '0},
        '{rrts_pkg::ACT_ADMIT,  6'd2,  32'h0,         0, '0},
        '{rrts_pkg::ACT_SLEEP,  6'd0,  32'hA5A5_A5A5, 0, '0},
        '{rrts_pkg::ACT_SLEEP,  6'd0,  32'hA5A5_A5A5, 0, '0},
        '{rrts_pkg::ACT_WAKEUP, 6'd0,  32'h5A5A_5A5A, 0, '0},
        '{rrts_pkg::ACT_WAKEUP, 6'd0,  32'hA5A5_A5A5, 0, '0},
        '{rrts_pkg::ACT_ADMIT,  6'd42, 32'h0,         0, '0}
    };

    // slice and tick settings per random phase, extremes included
    logic [rrts_pkg::SLICE_W-1:0] phase_slice [PHASES] =
        '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd10};
    logic [rrts_pkg::TICK_W-1:0]  phase_tick  [PHASES] =
        '{10'd1, 10'd0, 10'd1000, 10'd2, 10'd1023};

    initial begin
        mirror_reset();
        chan_pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1234_5678};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_action(directed[i].action, directed[i].thread_id, directed[i].channel,
                        directed[i].typed, directed[i].res);
        // hold the sender until every result is back
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            apb_write(3'(4 * rrts_pkg::REG_SLICE), 32'(phase_slice[p]));
            apb_write(3'(4 * rrts_pkg::REG_TICK), 32'(phase_tick[p]));
            repeat (RANDOM_PER_PHASE) random_action();
            drain_results();
        end

        repeat (200) @(posedge aclk);
        $display("Covered %0d results over %0d slice/tick settings: %0d switches,",
                 checked, PHASES + 1, switches);
        $display("  %0d empty-queue sleeps, %0d wakeups that woke threads.",
                 sleep_errors, wakeups_hit);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### round_robin_thread_scheduler.f
sv/rrts_pkg.sv
sv/rrts_thread_mem.sv
sv/rrts_fifo_mem.sv
sv/round_robin_thread_scheduler.sv
verif/tb.sv
